### hw/rtl/pqc_pkg.sv
// shared types, sizes and codes for the print queue with cancel
package pqc_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int POS_W       = 5;

	// request codes
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_LIST   = 2'd2;
	localparam logic [1:0] REQ_CANCEL = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// one stored document entry
	typedef struct packed {
		logic [63:0] name;
		logic [31:0] ext;
		logic [30:0] size;
		logic        color;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

### hw/rtl/print_queue_with_cancel_top.sv
// print job queue with pop, list and cancel by name, walked through one entry ram
//
// channel   direction  handshake              payload
// request   in         start high, busy low   req_type doc_name doc_ext doc_size doc_color
// result    out        strobe, one cycle      status position out_name out_ext out_size
//                                             out_color last
//
// add, and any request on an empty queue: result in the next cycle.
// pop: the head is reported by the scan, then the shift closes the gap.
// list: one entry read from the ram port per cycle.
// cancel: scan, re-read and shift when found; scan only when not found.
// reset clears state and entry count; the receiver cannot stall, so results never wait.
module print_queue_with_cancel_top
	import pqc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [63:0]       doc_name,
	input  logic [31:0]       doc_ext,
	input  logic [30:0]       doc_size,
	input  logic              doc_color,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [POS_W-1:0]  position,
	output logic [63:0]       out_name,
	output logic [31:0]       out_ext,
	output logic [30:0]       out_size,
	output logic              out_color,
	output logic              last
);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LIST  = 2'd1;
	localparam logic [1:0] S_FIND  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic             rv_s1;
	logic [IDX_W-1:0] ridx_s1;
	logic [63:0]      key_q;
	logic             pop_q;

	logic             strobe_q;
	logic [1:0]       status_q;
	logic [POS_W-1:0] position_q;
	entry_t           out_q;
	logic             last_q;

	logic             accept;
	logic             full;
	logic             add_wr;
	logic             shift_wr;
	logic             rd_en;
	logic             hit;
	logic             last_idx;
	logic [CNT_W-1:0] ridx_next;
	logic [POS_W-1:0] rpos;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           rd_data;
	entry_t           in_entry;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (cnt_q == CNT_W'(QUEUE_DEPTH));

	assign in_entry = '{name: doc_name, ext: doc_ext, size: doc_size, color: doc_color};

	// read pointer walks up to the entry count in every working state
	assign rd_en = busy && (ptr_q < cnt_q);

	// place of the entry now on the read data
	assign ridx_next = CNT_W'(ridx_s1) + CNT_W'(1);
	assign rpos      = POS_W'(ridx_next);
	assign last_idx  = (ridx_next == cnt_q);

	// shared name compare; a pop takes the head unconditionally
	assign hit = rv_s1 && (pop_q || (rd_data.name == key_q));

	// write port: tail append or move one entry up towards the head
	assign add_wr    = accept && (req_type == REQ_ADD) && !full;
	assign shift_wr  = (state_q == S_SHIFT) && rv_s1;
	assign ram_we    = add_wr || shift_wr;
	assign ram_waddr = add_wr ? cnt_q[IDX_W-1:0] : (ridx_s1 - IDX_W'(1));
	assign ram_wdata = add_wr ? in_entry : rd_data;

	pqc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ptr_q    <= '0;
			rv_s1    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			rv_s1    <= rd_en;
			if (rd_en) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						if (req_type == REQ_ADD) begin
							strobe_q <= 1'b1;
							if (!full) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end else if (cnt_q == '0) begin
							strobe_q <= 1'b1;
						end else if (req_type == REQ_LIST) begin
							state_q <= S_LIST;
						end else begin
							state_q <= S_FIND;
						end
					end
				end
				S_LIST: begin
					if (rv_s1) begin
						strobe_q <= 1'b1;
						if (last_idx) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FIND: begin
					if (hit) begin
						strobe_q <= 1'b1;
						state_q  <= S_SHIFT;
						ptr_q    <= ridx_next;
						rv_s1    <= 1'b0;
					end else if (rv_s1 && last_idx) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_SHIFT: begin
					if (!rd_en) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request key and kind
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= doc_name;
			pop_q <= (req_type == REQ_POP);
		end
		ridx_s1 <= ptr_q[IDX_W-1:0];
	end

	// result payload register
	always_ff @(posedge clk) begin
		last_q <= 1'b1;
		priority if (accept && (req_type == REQ_ADD) && !full) begin
			status_q   <= STAT_OK;
			position_q <= POS_W'(cnt_q + CNT_W'(1));
			out_q      <= in_entry;
		end else if (accept && (req_type == REQ_ADD)) begin
			status_q   <= STAT_FULL;
			position_q <= '0;
			out_q      <= '0;
		end else if (accept) begin
			status_q   <= STAT_EMPTY;
			position_q <= '0;
			out_q      <= '0;
		end else if ((state_q == S_LIST) && rv_s1) begin
			status_q   <= STAT_OK;
			position_q <= rpos;
			out_q      <= rd_data;
			last_q     <= last_idx;
		end else if ((state_q == S_FIND) && hit) begin
			status_q   <= STAT_OK;
			position_q <= rpos;
			out_q      <= rd_data;
		end else begin
			status_q   <= STAT_NOTFOUND;
			position_q <= '0;
			out_q      <= '0;
		end
	end

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign position  = position_q;
	assign out_name  = out_q.name;
	assign out_ext   = out_q.ext;
	assign out_size  = out_q.size;
	assign out_color = out_q.color;
	assign last      = last_q;

`ifndef SYNTHESIS
	// the entry count never passes the queue depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	// a scanned entry always lies inside the stored queue
	a_scan_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_s1 && (state_q != S_SHIFT)) |-> (CNT_W'(ridx_s1) < cnt_q))
		else $error("scan read outside stored entries");

	// closing the gap only writes below the entry count
	a_shift_inside: assert property (@(posedge clk) disable iff (!arst_n)
		shift_wr |-> (CNT_W'(ram_waddr) < cnt_q))
		else $error("shift write outside stored entries");

	// an accepted add on a queue with room grows the count by one
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_ADD) && !full) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("add did not grow the queue");

	// a failed request reports no place
	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status != STAT_OK)) |-> (position == '0))
		else $error("error result carries a position");
`endif

endmodule

### hw/rtl/pqc_ram.sv
// generic single write port ram with one registered read port
module pqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
